// File: src/bdeq_pkg.sv
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared sizes, codes, command and result types for the bounded deque.
// ----------------------------------------------------------------------------
package bdeq_pkg;

   localparam int DEPTH      = 32;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;
   localparam int EXT_W      = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [PTR_W-1:0]      ptr_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_DUMP       = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      func_type func;
      data_type value;
   } cmd_type;

   typedef struct packed {
      logic       valid;
      logic       from_ram;
      data_type   value;
      status_type status;
      logic       last;
   } result_type;

   // Truncate or zero-extend a request value to the stored width.
   function automatic data_type to_store(logic [31:0] v);
      logic [EXT_W-1:0] e;
      e = EXT_W'(v);
      return e[DATA_WIDTH-1:0];
   endfunction

   // Sign-extend a stored value and keep the low 32 bits.
   function automatic logic [31:0] to_out(data_type s);
      logic [EXT_W-1:0] e;
      e = EXT_W'(signed'(s));
      return e[31:0];
   endfunction

endpackage

// File: src/bdeq_ram.sv
// ----------------------------------------------------------------------------
// bdeq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bdeq_front.sv
// ----------------------------------------------------------------------------
// bdeq_front
// Request intake: handshake, function decode and command formatting.
// ----------------------------------------------------------------------------
module bdeq_front
   import bdeq_pkg::*;
(
   input  logic        start,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_push_value,
   input  logic        cmdq_full,
   output logic        busy,
   output logic        cmdq_wr,
   output cmd_type     cmdq_wr_cmd
);

   logic accept;
   logic known;

   assign busy   = cmdq_full;
   assign accept = start && !cmdq_full;
   // drop function codes above dump: no result, no state change
   assign known  = (req_func <= FUNC_DUMP);

   assign cmdq_wr           = accept && known;
   assign cmdq_wr_cmd.func  = func_type'(req_func);
   assign cmdq_wr_cmd.value = to_store(req_push_value);

endmodule

// File: src/bdeq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bdeq_cmd_fifo
// Short command queue between request intake and the execution engine.
// ----------------------------------------------------------------------------
module bdeq_cmd_fifo
   import bdeq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr,
   input  cmd_type wr_cmd,
   input  logic    rd,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type               slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff;
   logic [CMDQ_CNT_W-1:0] count_ff;
   logic [CMDQ_PTR_W-1:0] wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] count_in;
   logic                  do_wr;
   logic                  do_rd;

   assign full       = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_wr      = wr && !full;
   assign do_rd      = rd && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// File: src/bdeq_back.sv
// ----------------------------------------------------------------------------
// bdeq_back
// Execution engine: ring pointers, entry RAM access and the result pipeline.
// ----------------------------------------------------------------------------
module bdeq_back
   import bdeq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  cmd_type            head_cmd,
   output logic               cmdq_rd,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   state_type   state_ff, state_in;
   ptr_type     front_ff, front_in;
   cnt_type     count_ff, count_in;
   ptr_type     idx_ff, idx_in;
   cnt_type     remain_ff, remain_in;
   result_type  s1_ff, s1_in;
   logic        rsp_strobe_ff;
   logic [31:0] rsp_value_ff;
   status_type  rsp_status_ff;
   logic        rsp_last_ff;

   logic        wr_en;
   ptr_type     wr_addr;
   data_type    wr_data;
   logic        rd_en;
   ptr_type     rd_addr;
   data_type    rd_data;

   logic [SUM_W-1:0] tail_sum;
   logic [SUM_W-1:0] back_sum;
   ptr_type          back_free;
   ptr_type          back_used;
   ptr_type          front_dec;
   ptr_type          front_inc;
   ptr_type          idx_inc;
   logic             is_full;
   logic             is_empty;

   function automatic ptr_type ptr_inc(ptr_type p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic ptr_type ptr_wrap(logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] w;
      w = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
      return w[PTR_W-1:0];
   endfunction

   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign tail_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign back_sum  = tail_sum - SUM_W'(1);
   assign back_free = ptr_wrap(tail_sum);
   assign back_used = ptr_wrap(back_sum);
   assign front_dec = (front_ff == '0) ? PTR_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = ptr_inc(front_ff);
   assign idx_inc   = ptr_inc(idx_ff);

   always_comb begin
      state_in  = state_ff;
      front_in  = front_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      remain_in = remain_ff;
      s1_in     = '0;
      cmdq_rd   = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      wr_data   = head_cmd.value;
      rd_en     = 1'b0;
      rd_addr   = front_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               cmdq_rd = 1'b1;
               case (head_cmd.func)
                  FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                     s1_in.valid = 1'b1;
                     s1_in.value = head_cmd.value;
                     s1_in.last  = 1'b1;
                     if (is_full) begin
                        s1_in.status = STATUS_FULL;
                     end else begin
                        s1_in.status = STATUS_OK;
                        wr_en        = 1'b1;
                        count_in     = count_ff + 1'b1;
                        if (head_cmd.func == FUNC_PUSH_FRONT) begin
                           wr_addr  = front_dec;
                           front_in = front_dec;
                        end else begin
                           wr_addr = back_free;
                        end
                     end
                  end
                  FUNC_POP_FRONT, FUNC_POP_BACK: begin
                     s1_in.valid = 1'b1;
                     s1_in.last  = 1'b1;
                     if (is_empty) begin
                        s1_in.status = STATUS_EMPTY;
                     end else begin
                        s1_in.status   = STATUS_OK;
                        s1_in.from_ram = 1'b1;
                        rd_en          = 1'b1;
                        count_in       = count_ff - 1'b1;
                        if (head_cmd.func == FUNC_POP_FRONT) begin
                           rd_addr  = front_ff;
                           front_in = front_inc;
                        end else begin
                           rd_addr = back_used;
                        end
                     end
                  end
                  FUNC_DUMP: begin
                     s1_in.valid = 1'b1;
                     if (is_empty) begin
                        s1_in.status = STATUS_EMPTY;
                        s1_in.last   = 1'b1;
                     end else begin
                        // read the front entry now, walk the rest in ST_DUMP
                        s1_in.status   = STATUS_OK;
                        s1_in.from_ram = 1'b1;
                        s1_in.last     = (count_ff == CNT_W'(1));
                        rd_en          = 1'b1;
                        rd_addr        = front_ff;
                        idx_in         = front_inc;
                        remain_in      = count_ff - 1'b1;
                        if (count_ff != CNT_W'(1)) begin
                           state_in = ST_DUMP;
                        end
                     end
                  end
                  default: begin
                     s1_in = '0;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            s1_in.valid    = 1'b1;
            s1_in.from_ram = 1'b1;
            s1_in.status   = STATUS_OK;
            s1_in.last     = (remain_ff == CNT_W'(1));
            rd_en          = 1'b1;
            rd_addr        = idx_ff;
            idx_in         = idx_inc;
            remain_in      = remain_ff - 1'b1;
            if (remain_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         front_ff      <= '0;
         count_ff      <= '0;
         s1_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         remain_ff     <= remain_in;
         s1_ff         <= s1_in;
         rsp_strobe_ff <= s1_ff.valid;
         rsp_value_ff  <= s1_ff.from_ram ? to_out(rd_data) : to_out(s1_ff.value);
         rsp_status_ff <= s1_ff.status;
         rsp_last_ff   <= s1_ff.last;
      end
   end

   bdeq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_value = signed'(rsp_value_ff);
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: src/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Ring-buffer deque: push/pop at either end and front-to-back dump.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low:
// req_func selects push front, push back, pop front, pop back or dump, and
// req_push_value carries the value for a push. Unknown function codes are
// taken and dropped without a result.
// Each result shows on rsp_out_value, rsp_status and rsp_last for one cycle
// with rsp_strobe high; the receiver cannot hold it off, and none is needed.
// A decoded request waits in a two-entry command queue; busy is high while
// that queue is full. Outside a dump the engine starts one push or pop a
// cycle, so those requests sustain one per cycle; each result passes the
// s1 register (with the entry RAM read, for a pop) and then the output
// register. A dump holds the engine until every entry is read, one entry
// RAM read per cycle, and streams its results with rsp_last on the final one.
// Reset empties the queue and zeroes the front pointer; the entry RAM is not
// cleared, since only occupied entries are ever read.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
   import bdeq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   logic    cmdq_full;
   logic    cmdq_wr;
   cmd_type cmdq_wr_cmd;
   logic    cmdq_rd;
   logic    head_valid;
   cmd_type head_cmd;

   bdeq_front u_front (
      .start          (start),
      .req_func       (req_func),
      .req_push_value ($unsigned(req_push_value)),
      .cmdq_full      (cmdq_full),
      .busy           (busy),
      .cmdq_wr        (cmdq_wr),
      .cmdq_wr_cmd    (cmdq_wr_cmd)
   );

   bdeq_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr         (cmdq_wr),
      .wr_cmd     (cmdq_wr_cmd),
      .rd         (cmdq_rd),
      .full       (cmdq_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   bdeq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_cmd      (head_cmd),
      .cmdq_rd       (cmdq_rd),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_value (rsp_out_value),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule
